[design/mws_pkg.sv]
// ----------------------------------------------------------------------------
// mws_pkg: shared types and constants for the minimum window subsequence core
// Sizes of the pattern, the text position and the symbols, register indexes,
// and the structs that pass between the prefix cells, the output buffer and
// the top level.
// ----------------------------------------------------------------------------
package mws_pkg;

   // sizes
   localparam int PATTERN_MAX = 16;
   localparam int TEXT_MAX    = 65536;
   localparam int SYMBOL_BITS = 16;
   localparam int SLOT_BITS   = 16;
   localparam int POS_BITS    = $clog2(TEXT_MAX + 1);
   localparam int PIDX_BITS   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int OUT_BITS    = 17;
   localparam int PLEN_BITS   = 5;
   localparam int WORD_BITS   = 64;
   localparam int NUM_WORDS   = 4;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_IDX_BITS  = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd4;

   // broadcast from the top level to every prefix cell
   typedef struct packed {
      logic                   advance;
      logic                   clear;
      logic                   match_en;
      logic [SYMBOL_BITS-1:0] symbol;
      logic [POS_BITS-1:0]    position;
   } cell_ctrl_type;

   // what one cell reports for the current request
   typedef struct packed {
      logic                hit;
      logic [POS_BITS-1:0] start;
   } cell_out_type;

   // one result
   typedef struct packed {
      logic                found;
      logic [OUT_BITS-1:0] best_length;
      logic [OUT_BITS-1:0] best_start;
      logic                text_done;
      logic                position_overflow;
   } result_type;

endpackage

[design/mws_cell.sv]
// ----------------------------------------------------------------------------
// mws_cell: one pattern prefix cell
// Holds the latest text start from which its prefix is matched and passes it
// to the next cell; takes over the start of the previous cell on a symbol hit,
// or the current position in the head cell.
module mws_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  mws_pkg::cell_ctrl_type              ctrl,
   input  logic                                head,
   input  logic                                active,
   input  logic [mws_pkg::SYMBOL_BITS-1:0]     pat_symbol,
   input  logic [mws_pkg::POS_BITS-1:0]        prev_start,
   output logic [mws_pkg::POS_BITS-1:0]        start,
   output mws_pkg::cell_out_type               result
);
   import mws_pkg::*;

   logic [POS_BITS-1:0] start_ff;
   logic [POS_BITS-1:0] start_in;
   logic                hit;
   logic [POS_BITS-1:0] new_start;

   // the first prefix starts at the current position, later ones inherit
   assign new_start = head ? ctrl.position : prev_start;
   assign hit = ctrl.match_en && active && (ctrl.symbol == pat_symbol) &&
                (head || (prev_start != '0));

   // next stored start
   always_comb begin
      start_in = start_ff;
      if (ctrl.advance) begin
         if (ctrl.clear) begin
            start_in = '0;
         end else if (hit) begin
            start_in = new_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else begin
         start_ff <= start_in;
      end
   end

   assign start        = start_ff;
   assign result.hit   = hit;
   assign result.start = new_start;

endmodule

[design/mws_skid.sv]
// ----------------------------------------------------------------------------
// mws_skid: two-entry output buffer
// Output register plus a skid register so the request side keeps flowing
// while a result waits on the response side.
// ----------------------------------------------------------------------------
module mws_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mws_pkg::result_type  push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   output mws_pkg::result_type  out_data,
   input  logic                 out_ready
);
   import mws_pkg::*;

   logic       main_valid_ff;
   logic       main_valid_in;
   result_type main_data_ff;
   result_type main_data_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       take;

   assign take       = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;

   // buffer steering
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

[design/min_window_subsequence_core.sv]
// ----------------------------------------------------------------------------
// min_window_subsequence_core: shortest text window holding a pattern
// Row of prefix cells updated once per text symbol, best window tracking and
// a two-entry output buffer; APB-style register port for the pattern.
// ----------------------------------------------------------------------------
// output: a request's result is registered in the output buffer, then offered on rsp
// throughput: one request per cycle while the skid register is empty, set by the
//   prefix cell row and the best window compare that closes on itself
// reset: synchronous, clears all cells, position, best window and buffers;
//   pattern_length returns to 1 and the pattern words to 0
module min_window_subsequence_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: [15:0] text_symbol
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,
   input  logic                                 req_tlast,
   // response: [16:0] best_length, [33:17] best_start, [39:34] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [39:0]                          rsp_tdata,
   // response flags: [0] found, [1] position_overflow
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mws_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mws_pkg::WORD_BITS-1:0]        csr_pwdata,
   output logic [mws_pkg::WORD_BITS-1:0]        csr_prdata,
   output logic                                 csr_pready
);
   import mws_pkg::*;

   logic [PLEN_BITS-1:0]    pattern_length_ff;
   logic [WORD_BITS-1:0]    pattern_word_ff [NUM_WORDS];
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic                    csr_write;

   logic [POS_BITS-1:0]     position_ff;
   logic [POS_BITS-1:0]     position_in;
   logic [POS_BITS-1:0]     best_len_ff;
   logic [POS_BITS-1:0]     best_len_in;
   logic [POS_BITS-1:0]     best_start_ff;
   logic [POS_BITS-1:0]     best_start_in;
   logic                    have_window_ff;
   logic                    have_window_in;
   logic                    overflow_ff;
   logic                    overflow_in;

   logic                    req_fire;
   logic                    saturated;
   logic [POS_BITS-1:0]     pos_next;
   logic [PLEN_BITS-1:0]    used_len;
   logic [PIDX_BITS-1:0]    last_idx;
   cell_ctrl_type           cell_ctrl;
   logic [POS_BITS-1:0]     cell_start [PATTERN_MAX];
   cell_out_type            cell_res   [PATTERN_MAX];
   cell_out_type            tail;
   logic [POS_BITS-1:0]     win_len;
   logic                    win_better;
   logic [POS_BITS-1:0]     upd_pos;
   logic [POS_BITS-1:0]     upd_len;
   logic [POS_BITS-1:0]     upd_start;
   logic                    upd_have;
   logic                    upd_ovf;
   result_type              result;
   result_type              rsp_data;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1 -: CSR_IDX_BITS];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= PLEN_BITS'(1);
         for (int i = 0; i < NUM_WORDS; i++) begin
            pattern_word_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_PATTERN_LENGTH: pattern_length_ff  <= csr_pwdata[PLEN_BITS-1:0];
            REG_PATTERN_WORD_0: pattern_word_ff[0] <= csr_pwdata;
            REG_PATTERN_WORD_1: pattern_word_ff[1] <= csr_pwdata;
            REG_PATTERN_WORD_2: pattern_word_ff[2] <= csr_pwdata;
            REG_PATTERN_WORD_3: pattern_word_ff[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PATTERN_LENGTH: csr_prdata = WORD_BITS'(pattern_length_ff);
         REG_PATTERN_WORD_0: csr_prdata = pattern_word_ff[0];
         REG_PATTERN_WORD_1: csr_prdata = pattern_word_ff[1];
         REG_PATTERN_WORD_2: csr_prdata = pattern_word_ff[2];
         REG_PATTERN_WORD_3: csr_prdata = pattern_word_ff[3];
         default:            csr_prdata = '0;
      endcase
   end

   // pattern length in use, clamped to one through the cell count
   always_comb begin
      used_len = pattern_length_ff;
      if (used_len == '0) begin
         used_len = PLEN_BITS'(1);
      end else if (used_len > PLEN_BITS'(PATTERN_MAX)) begin
         used_len = PLEN_BITS'(PATTERN_MAX);
      end
   end
   assign last_idx = PIDX_BITS'(used_len - PLEN_BITS'(1));

   // broadcast to the cell row
   assign req_fire  = req_tvalid && req_tready;
   assign saturated = (position_ff == POS_BITS'(TEXT_MAX));
   assign pos_next  = position_ff + POS_BITS'(1);

   assign cell_ctrl.advance  = req_fire;
   assign cell_ctrl.clear    = req_tlast;
   assign cell_ctrl.match_en = !saturated;
   assign cell_ctrl.symbol   = req_tdata[SYMBOL_BITS-1:0];
   assign cell_ctrl.position = pos_next;

   // prefix cell row, each cell reads its left neighbor's stored start
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [POS_BITS-1:0] prev;
      if (k == 0) begin : g_head
         assign prev = '0;
      end else begin : g_link
         assign prev = cell_start[k-1];
      end
      mws_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .head       (k == 0),
         .active     (PIDX_BITS'(k) <= last_idx),
         .pat_symbol (pattern_word_ff[k / 4][(k % 4) * SLOT_BITS +: SYMBOL_BITS]),
         .prev_start (prev),
         .start      (cell_start[k]),
         .result     (cell_res[k])
      );
   end

   // completion of the full pattern
   assign tail       = cell_res[last_idx];
   assign win_len    = pos_next - tail.start + POS_BITS'(1);
   assign win_better = tail.hit && (!have_window_ff || (win_len < best_len_ff));

   // running best and position
   always_comb begin
      upd_pos   = position_ff;
      upd_len   = best_len_ff;
      upd_start = best_start_ff;
      upd_have  = have_window_ff;
      upd_ovf   = overflow_ff;
      if (saturated) begin
         upd_ovf = 1'b1;
      end else begin
         upd_pos = pos_next;
      end
      if (win_better) begin
         upd_have  = 1'b1;
         upd_len   = win_len;
         upd_start = tail.start;
      end
   end

   assign result.found             = upd_have;
   assign result.best_length       = upd_have ? OUT_BITS'(upd_len) : '0;
   assign result.best_start        = upd_have ? OUT_BITS'(upd_start) : '0;
   assign result.text_done         = req_tlast;
   assign result.position_overflow = upd_ovf;

   // state update, cleared after the last symbol of a text
   always_comb begin
      position_in    = position_ff;
      best_len_in    = best_len_ff;
      best_start_in  = best_start_ff;
      have_window_in = have_window_ff;
      overflow_in    = overflow_ff;
      if (req_fire) begin
         if (req_tlast) begin
            position_in    = '0;
            best_len_in    = '0;
            best_start_in  = '0;
            have_window_in = 1'b0;
            overflow_in    = 1'b0;
         end else begin
            position_in    = upd_pos;
            best_len_in    = upd_len;
            best_start_in  = upd_start;
            have_window_in = upd_have;
            overflow_in    = upd_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         best_len_ff    <= '0;
         best_start_ff  <= '0;
         have_window_ff <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         position_ff    <= position_in;
         best_len_ff    <= best_len_in;
         best_start_ff  <= best_start_in;
         have_window_ff <= have_window_in;
         overflow_ff    <= overflow_in;
      end
   end

   // output buffer
   mws_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp_data),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {6'b0, rsp_data.best_start, rsp_data.best_length};
   assign rsp_tuser = {rsp_data.position_overflow, rsp_data.found};
   assign rsp_tlast = rsp_data.text_done;

   // checks
   a_have_len: assert property (@(posedge clock) disable iff (reset)
      have_window_ff |-> (best_len_ff != '0) && (best_start_ff != '0))
      else $error("window recorded with zero length or start");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      !have_window_ff |-> (best_len_ff == '0) && (best_start_ff == '0))
      else $error("best window fields set without a window");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_BITS'(TEXT_MAX))
      else $error("position beyond text limit");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> saturated)
      else $error("overflow flag without saturated position");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (position_ff == '0) && !have_window_ff && !overflow_ff)
      else $error("state not cleared after last symbol");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for min_window_subsequence_core
// Sends text symbols on the request stream and loads patterns over the
// register port. A local model tracks prefix starts and the shortest window,
// and every response is compared field by field with the model's value, while
// both stream sides pause at random.
// ----------------------------------------------------------------------------
module tb_top;
   import mws_pkg::*;

   // no register decodes at this index
   localparam logic [CSR_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;
   localparam int IDLE_PERCENT = 22;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // [15:0] text_symbol
   logic [15:0]              req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [16:0] best_length, [33:17] best_start, [39:34] zero
   logic [39:0]              rsp_tdata;
   // [0] found, [1] position_overflow
   logic [1:0]               rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [WORD_BITS-1:0]     csr_pwdata = '0;
   logic [WORD_BITS-1:0]     csr_prdata;
   logic                     csr_pready;

   logic no_idle = 1'b0;
   int   errors = 0;

   // copy of the pattern registers
   logic [PLEN_BITS-1:0] pattern_len = 5'd1;
   logic [WORD_BITS-1:0] pattern_words [NUM_WORDS] = '{default: '0};

   // copy of the per-text search state
   logic [POS_BITS-1:0] prefix_from [PATTERN_MAX];
   logic [POS_BITS-1:0] text_pos;
   logic [OUT_BITS-1:0] shortest_len;
   logic [OUT_BITS-1:0] shortest_start;
   logic                window_seen;
   logic                text_overflowed;

   result_type pending_windows [$];
   result_type oldest_window;

   min_window_subsequence_core dut (.*);

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_search();
      foreach (prefix_from[k]) prefix_from[k] = '0;
      text_pos        = '0;
      shortest_len    = '0;
      shortest_start  = '0;
      window_seen     = 1'b0;
      text_overflowed = 1'b0;
   endfunction

   // one text symbol: update prefix starts and the best window
   function automatic result_type advance_window_search(logic [15:0] sym, logic last);
      result_type          res;
      int                  m;
      logic [POS_BITS-1:0] here;
      logic [OUT_BITS-1:0] span;
      if (pattern_len == 0) m = 1;
      else if (pattern_len > PATTERN_MAX) m = PATTERN_MAX;
      else m = int'(pattern_len);
      if (text_pos >= TEXT_MAX) begin
         text_overflowed = 1'b1;
      end else begin
         here = text_pos + 1'b1;
         text_pos = here;
         // descending so each prefix sees the previous symbol's starts
         for (int k = m - 1; k >= 0; k--) begin
            if (sym == pattern_words[k / 4][(k % 4) * SLOT_BITS +: SLOT_BITS] &&
                (k == 0 || prefix_from[k - 1] != 0)) begin
               prefix_from[k] = (k == 0) ? here : prefix_from[k - 1];
               if (k == m - 1) begin
                  span = here - prefix_from[k] + 1'b1;
                  // strictly shorter only, so the earlier window wins ties
                  if (!window_seen || span < shortest_len) begin
                     window_seen    = 1'b1;
                     shortest_len   = span;
                     shortest_start = prefix_from[k];
                  end
               end
            end
         end
      end
      res.found             = window_seen;
      res.best_length       = window_seen ? shortest_len : '0;
      res.best_start        = window_seen ? shortest_start : '0;
      res.text_done         = last;
      res.position_overflow = text_overflowed;
      if (last) clear_search();
      return res;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // response side: random stalls and field checks
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_windows.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            oldest_window = pending_windows.pop_front();
            compare_field("found", oldest_window.found, rsp_tuser[0]);
            compare_field("best_length", oldest_window.best_length, rsp_tdata[16:0]);
            compare_field("best_start", oldest_window.best_start, rsp_tdata[33:17]);
            compare_field("text_done", oldest_window.text_done, rsp_tlast);
            compare_field("position_overflow", oldest_window.position_overflow,
                          rsp_tuser[1]);
         end
      end
   end

   // one request, with random gaps ahead of it
   task automatic send_symbol(input logic [15:0] sym, input logic last);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_windows.push_back(advance_window_search(sym, last));
   endtask

   // stop sending and wait for every outstanding response
   task automatic settle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
   endtask

   // setup and access phase, then an idle phase on the bus
   task automatic write_register(input logic [CSR_IDX_BITS-1:0] idx,
                                 input logic [WORD_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PATTERN_LENGTH: pattern_len = value[PLEN_BITS-1:0];
         REG_PATTERN_WORD_0: pattern_words[0] = value;
         REG_PATTERN_WORD_1: pattern_words[1] = value;
         REG_PATTERN_WORD_2: pattern_words[2] = value;
         REG_PATTERN_WORD_3: pattern_words[3] = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_pattern(input logic [PLEN_BITS-1:0] len,
                                input logic [WORD_BITS-1:0] words [NUM_WORDS]);
      write_register(REG_PATTERN_LENGTH, WORD_BITS'(len));
      for (int i = 0; i < NUM_WORDS; i++)
         write_register(REG_PATTERN_WORD_0 + CSR_IDX_BITS'(i), words[i]);
   endtask

   // reset pattern is the single symbol zero
   task automatic test_reset_pattern();
      send_symbol(16'd7, 1'b0);
      send_symbol(16'd0, 1'b0);
      send_symbol(16'd0, 1'b0);
      send_symbol(16'hFFFF, 1'b1);
      settle();
   endtask

   // shorter window replaces, equal length keeps the earlier, extreme symbols
   task automatic test_window_rules();
      write_register(REG_PATTERN_LENGTH, 64'd2);
      write_register(REG_PATTERN_WORD_0, 64'h0000_0000_0002_0001);
      send_symbol(16'd1, 1'b0);
      send_symbol(16'd7, 1'b0);
      send_symbol(16'd2, 1'b0);
      send_symbol(16'd1, 1'b0);
      send_symbol(16'd2, 1'b0);
      send_symbol(16'd1, 1'b0);
      send_symbol(16'd2, 1'b1);
      settle();
      write_register(REG_PATTERN_LENGTH, 64'd3);
      write_register(REG_PATTERN_WORD_0, 64'h0000_FFFF_0000_FFFF);
      send_symbol(16'hFFFF, 1'b0);
      send_symbol(16'h0000, 1'b0);
      send_symbol(16'h0000, 1'b0);
      send_symbol(16'hFFFF, 1'b1);
      settle();
   endtask

   // length zero acts as one, lengths past the maximum act as the maximum
   task automatic test_length_limits();
      logic [WORD_BITS-1:0] words [NUM_WORDS];
      for (int k = 0; k < PATTERN_MAX; k++)
         words[k / 4][(k % 4) * SLOT_BITS +: SLOT_BITS] = 16'hA000 + 16'(k);
      write_pattern(5'd0, words);
      send_symbol(16'd5, 1'b0);
      send_symbol(16'hA000, 1'b1);
      settle();
      write_register(REG_PATTERN_LENGTH, 64'd31);
      for (int k = 0; k < PATTERN_MAX; k++)
         send_symbol(16'hA000 + 16'(k), k == PATTERN_MAX - 1);
      settle();
   endtask

   // a write to an unused index must leave the pattern alone
   task automatic test_unmapped_register();
      write_register(REG_PATTERN_LENGTH, 64'd1);
      write_register(REG_PATTERN_WORD_0, 64'h0000_0000_0000_00FF);
      write_register(REG_UNMAPPED, '1);
      send_symbol(16'hFFFF, 1'b0);
      send_symbol(16'h00FF, 1'b1);
      settle();
   endtask

   // new pattern mid-text keeps the stored prefix starts
   task automatic test_pattern_change_mid_text();
      write_register(REG_PATTERN_LENGTH, 64'd2);
      write_register(REG_PATTERN_WORD_0, 64'h0000_0000_0002_0001);
      send_symbol(16'd1, 1'b0);
      send_symbol(16'd9, 1'b0);
      settle();
      write_register(REG_PATTERN_WORD_0, 64'h0000_0000_0002_0005);
      send_symbol(16'd2, 1'b1);
      settle();
   endtask

   // random patterns over a small alphabet so that windows are common
   task automatic test_random_texts(input int phases, input int phase_items);
      logic [15:0]          alphabet [4];
      logic [WORD_BITS-1:0] words [NUM_WORDS];
      logic [PLEN_BITS-1:0] len;
      logic [15:0]          sym;
      int                   letters;
      int                   sent;
      int                   text_len;
      for (int ph = 0; ph < phases; ph++) begin
         settle();
         letters = $urandom_range(1, 4);
         foreach (alphabet[i]) alphabet[i] = 16'($urandom);
         case ($urandom_range(0, 9))
            0: len = 5'(PATTERN_MAX);
            1: len = 5'($urandom_range(0, 31));
            default: len = 5'($urandom_range(1, 5));
         endcase
         for (int k = 0; k < PATTERN_MAX; k++)
            words[k / 4][(k % 4) * SLOT_BITS +: SLOT_BITS] =
               alphabet[$urandom_range(0, letters - 1)];
         // occasional noise pattern
         if ($urandom_range(0, 9) == 0) foreach (words[i]) words[i] = {$urandom, $urandom};
         write_pattern(len, words);
         if ($urandom_range(0, 3) == 0) write_register(REG_UNMAPPED, {$urandom, $urandom});
         sent = 0;
         while (sent < phase_items) begin
            text_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 30);
            for (int i = 0; i < text_len; i++) begin
               if ($urandom_range(0, 99) < 85) sym = alphabet[$urandom_range(0, letters - 1)];
               else sym = 16'($urandom);
               // most texts end with the last flag, some run on into the next
               send_symbol(sym, i == text_len - 1 && $urandom_range(0, 9) != 0);
            end
            sent += text_len;
         end
      end
      settle();
   endtask

   // main sequence
   initial begin
      clear_search();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_pattern();
      test_window_rules();
      test_length_limits();
      test_unmapped_register();
      test_pattern_change_mid_text();
      test_random_texts(5, 140);
      no_idle <= 1'b1;
      test_random_texts(2, 140);
      no_idle <= 1'b0;
      test_random_texts(3, 140);
      settle();
      repeat (4) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
design/mws_pkg.sv
design/mws_cell.sv
design/mws_skid.sv
design/min_window_subsequence_core.sv
sim/tb_top.sv
